// ===== src/fts_pkg.sv =====
// Package for the frequency table target select block.
// Holds sizes, codes and the scan beat types shared by the cell row and the top level.
// No dependencies.
package fts_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int FREQ_W      = 32;
  localparam int SLOT_W      = 4;
  localparam int CHOSEN_W    = 4;
  localparam int CNT_REG_W   = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Input item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Relation codes.
  localparam logic REL_AT_OR_ABOVE = 1'b0;
  localparam logic REL_AT_OR_BELOW = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

  // Running search state carried from cell to cell.
  typedef struct packed {
    logic              high_side;
    logic [FREQ_W-1:0] target;
    logic [FREQ_W-1:0] best_f;
    logic [IDX_W-1:0]  best_i;
    logic              best_ok;
    logic [FREQ_W-1:0] alt_f;
    logic [IDX_W-1:0]  alt_i;
    logic              alt_ok;
  } scan_pay_t;

  typedef struct packed {
    logic      vld;
    scan_pay_t pay;
  } scan_tok_t;

  // Selection limits seen by every cell.
  typedef struct packed {
    logic [FREQ_W-1:0] pol_min;
    logic [FREQ_W-1:0] pol_max;
    logic [CNT_W-1:0]  limit;
  } scan_cfg_t;

endpackage

// ===== src/fts_cell.sv =====
// One table cell: holds a single frequency entry and its valid mark, and
// updates the search beat passing through it. Depends on fts_pkg.
module fts_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fts_pkg::IDX_W-1:0] cell_idx,
  input  logic                      wr_en,
  input  logic [fts_pkg::FREQ_W-1:0] wr_freq,
  input  logic                      wr_ok,
  input  fts_pkg::scan_cfg_t        cfg,
  input  fts_pkg::scan_tok_t        tok_in,
  output fts_pkg::scan_tok_t        tok_out
);

  logic [fts_pkg::FREQ_W-1:0] freq_r;
  logic                       ok_r;
  logic                       vld_r;
  fts_pkg::scan_pay_t         pay_r;
  fts_pkg::scan_pay_t         pay_nxt;
  logic                       usable;
  logic                       on_best_side;

  // The frequency itself has no reset; it is only looked at once the mark is set.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_r <= wr_freq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (wr_en) begin
      ok_r <= wr_ok;
    end
  end

  always_comb begin
    usable = ok_r && (fts_pkg::CNT_W'(cell_idx) < cfg.limit) &&
             (freq_r >= cfg.pol_min) && (freq_r <= cfg.pol_max);
    on_best_side = (tok_in.pay.high_side == fts_pkg::REL_AT_OR_BELOW) ?
                   (freq_r <= tok_in.pay.target) : (freq_r >= tok_in.pay.target);
    pay_nxt = tok_in.pay;
    if (usable) begin
      if (on_best_side) begin
        if ((tok_in.pay.high_side == fts_pkg::REL_AT_OR_BELOW) ?
            (freq_r >= tok_in.pay.best_f) : (freq_r <= tok_in.pay.best_f)) begin
          pay_nxt.best_f  = freq_r;
          pay_nxt.best_i  = cell_idx;
          pay_nxt.best_ok = 1'b1;
        end
      end else begin
        if ((tok_in.pay.high_side == fts_pkg::REL_AT_OR_BELOW) ?
            (freq_r <= tok_in.pay.alt_f) : (freq_r >= tok_in.pay.alt_f)) begin
          pay_nxt.alt_f  = freq_r;
          pay_nxt.alt_i  = cell_idx;
          pay_nxt.alt_ok = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
  end

  assign tok_out.vld = vld_r;
  assign tok_out.pay = pay_r;

endmodule

// ===== src/frequency_table_target_select.sv =====
// Top level of the frequency table target select block: row of table cells,
// query injection, result register and configuration registers. Depends on fts_pkg, fts_cell.
//
//  Channel | Ports                                              | Direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid, in_stall, in_func, in_entry_slot,        | in
//          | in_entry_freq, in_entry_ok, in_target_freq,        |
//          | in_relation                                        |
//  result  | out_valid, out_stall, out_chosen_index,            | out
//          | out_not_found                                      |
//  config  | cfg_we, cfg_index, cfg_wdata                       | in
//
// A write beat produces no result. A query beat enters a search beat into the
// first cell; it moves one cell per cycle along the row of TABLE_DEPTH cells
// and then into the output register, and the next beat can be taken once the
// result has left the row. The length of the cell row sets how long a query
// stays in flight. Reset (rst_n low, synchronous) clears every valid mark, the
// control flags, the policy minimum and the entry count, sets the policy
// maximum to all ones, and leaves stored frequencies as they are.
// A finished result may wait in a second register while the output stalls;
// the input stalls only while a query is in the row or that register is full.
module frequency_table_target_select (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [fts_pkg::SLOT_W-1:0]      in_entry_slot,
  input  logic [fts_pkg::FREQ_W-1:0]      in_entry_freq,
  input  logic                            in_entry_ok,
  input  logic [fts_pkg::FREQ_W-1:0]      in_target_freq,
  input  logic                            in_relation,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fts_pkg::CHOSEN_W-1:0]    out_chosen_index,
  output logic                            out_not_found,
  input  logic                            cfg_we,
  input  logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers.
  logic [fts_pkg::FREQ_W-1:0]    pol_min_r;
  logic [fts_pkg::FREQ_W-1:0]    pol_max_r;
  logic [fts_pkg::CNT_REG_W-1:0] entry_count_r;

  // Control state.
  logic busy_r;
  logic busy_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic pend_vld_r;
  logic pend_vld_nxt;

  // Result payload.
  logic [fts_pkg::CHOSEN_W-1:0] out_idx_r;
  logic [fts_pkg::CHOSEN_W-1:0] out_idx_nxt;
  logic                         out_nf_r;
  logic                         out_nf_nxt;
  logic [fts_pkg::CHOSEN_W-1:0] pend_idx_r;
  logic [fts_pkg::CHOSEN_W-1:0] pend_idx_nxt;
  logic                         pend_nf_r;
  logic                         pend_nf_nxt;

  logic in_acc;
  logic query_acc;
  logic write_acc;
  logic out_take;
  logic scan_done;
  logic [fts_pkg::CHOSEN_W-1:0] res_idx;
  logic                         res_nf;

  fts_pkg::scan_cfg_t scan_cfg;
  fts_pkg::scan_tok_t tok [fts_pkg::TABLE_DEPTH+1];
  logic [fts_pkg::TABLE_DEPTH-1:0] tok_vld_vec;

  assign in_stall  = busy_r || pend_vld_r;
  assign in_acc    = in_valid && !in_stall;
  assign query_acc = in_acc && (in_func == fts_pkg::FUNC_QUERY);
  assign write_acc = in_acc && (in_func == fts_pkg::FUNC_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_min_r     <= '0;
      pol_max_r     <= '1;
      entry_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fts_pkg::CFG_POLICY_MIN:  pol_min_r     <= cfg_wdata;
        fts_pkg::CFG_POLICY_MAX:  pol_max_r     <= cfg_wdata;
        fts_pkg::CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata[fts_pkg::CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // An entry count beyond the table depth is clamped to the depth.
  always_comb begin
    scan_cfg.pol_min = pol_min_r;
    scan_cfg.pol_max = pol_max_r;
    if (32'(entry_count_r) > fts_pkg::TABLE_DEPTH) begin
      scan_cfg.limit = fts_pkg::CNT_W'(fts_pkg::TABLE_DEPTH);
    end else begin
      scan_cfg.limit = fts_pkg::CNT_W'(entry_count_r);
    end
  end

  // The search beat starts with the best side empty at its worst value and
  // the fallback side empty at the opposite extreme.
  always_comb begin
    tok[0].vld           = query_acc;
    tok[0].pay.high_side = in_relation;
    tok[0].pay.target    = in_target_freq;
    tok[0].pay.best_f    = (in_relation == fts_pkg::REL_AT_OR_BELOW) ? '0 : '1;
    tok[0].pay.best_i    = '0;
    tok[0].pay.best_ok   = 1'b0;
    tok[0].pay.alt_f     = (in_relation == fts_pkg::REL_AT_OR_BELOW) ? '1 : '0;
    tok[0].pay.alt_i     = '0;
    tok[0].pay.alt_ok    = 1'b0;
  end

  // One cell per table slot. The slot field spans exactly the depth, so every write hits one cell.
  for (genvar g = 0; g < fts_pkg::TABLE_DEPTH; g++) begin : g_cell
    logic wr_hit;
    assign wr_hit = write_acc && (32'(in_entry_slot) == g);
    assign tok_vld_vec[g] = tok[g+1].vld;

    fts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (fts_pkg::IDX_W'(g)),
      .wr_en    (wr_hit),
      .wr_freq  (in_entry_freq),
      .wr_ok    (in_entry_ok),
      .cfg      (scan_cfg),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  // The best match wins; otherwise the nearest entry on the other side;
  // otherwise nothing was found and the index reads as zero.
  assign scan_done = tok[fts_pkg::TABLE_DEPTH].vld;

  always_comb begin
    if (tok[fts_pkg::TABLE_DEPTH].pay.best_ok) begin
      res_idx = fts_pkg::CHOSEN_W'(tok[fts_pkg::TABLE_DEPTH].pay.best_i);
      res_nf  = 1'b0;
    end else if (tok[fts_pkg::TABLE_DEPTH].pay.alt_ok) begin
      res_idx = fts_pkg::CHOSEN_W'(tok[fts_pkg::TABLE_DEPTH].pay.alt_i);
      res_nf  = 1'b0;
    end else begin
      res_idx = '0;
      res_nf  = 1'b1;
    end
  end

  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_nf_nxt    = out_nf_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    pend_nf_nxt   = pend_nf_r;

    if (query_acc) begin
      busy_nxt = 1'b1;
    end else if (scan_done) begin
      busy_nxt = 1'b0;
    end

    if (!out_valid_r || out_take) begin
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = pend_idx_r;
        out_nf_nxt    = pend_nf_r;
        pend_vld_nxt  = 1'b0;
      end else if (scan_done) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = res_idx;
        out_nf_nxt    = res_nf;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (scan_done) begin
      // The output is held, so the fresh result waits in the second register.
      pend_vld_nxt = 1'b1;
      pend_idx_nxt = res_idx;
      pend_nf_nxt  = res_nf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_nf_r   <= out_nf_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_nf_r  <= pend_nf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;
  assign out_not_found    = out_nf_r;

`ifndef NO_ASSERTIONS
  // At most one search beat is ever in the cell row.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld_vec) <= 1)
    else $error("more than one search beat in the cell row");

  // A beat in the row always belongs to a query that is still marked busy.
  a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_vld_vec != '0) |-> busy_r)
    else $error("search beat in flight without busy flag");

  // The waiting result register is only filled behind a full output register.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (out_valid_r && !busy_r))
    else $error("waiting result without a held output or with a query in flight");

  // An accepted query enters the first cell on the next edge.
  a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> tok[1].vld)
    else $error("accepted query did not enter the cell row");
`endif

endmodule
